### sv/luw_pkg.sv
// ----------------------------------------------------------------------------
// luw_pkg - shared types for the longest uniform window block
// Field widths and the packed payloads of the input and result channels.
// ----------------------------------------------------------------------------
package luw_pkg;

  localparam int LETTER_W  = 5;   // letter code, 0 for A through 25 for Z
  localparam int CFG_W     = 13;  // max_changes register
  localparam int BEST_W    = 13;  // reported window length

  typedef struct packed {
    logic [LETTER_W-1:0] letter;
    logic                last_of_string;
  } in_item_t;

  typedef struct packed {
    logic [BEST_W-1:0] best_length;
    logic              is_final;
    logic              overflow;
  } out_item_t;

endpackage

### sv/longest_uniform_window_after_k_changes.sv
// ----------------------------------------------------------------------------
// longest_uniform_window_after_k_changes
// Sliding-window tracker over a letter string: after every letter, reports
// the longest window seen so far that max_changes replacements make uniform.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake          payload
//  -------  ---  -----------------  ---------------------------------------
//  in_      in   in_valid/in_ready  in_item   {letter, last_of_string}
//  out_     out  out_valid/out_ready out_item {best_length, is_final, overflow}
//  cfg_     in   cfg_valid/cfg_ready cfg_max_changes (always ready)
//
//  One letter per cycle sustained. A result passes from its input transfer
//  through the stage register (window buffer read) and the output register
//  before it is presented. Reset and the last letter of a string clear all
//  string state; the buffer needs no clearing since only entries written
//  earlier in the same string are ever read. A full, stalled output
//  register holds the stage behind it; in_ready drops once that stage is
//  occupied too, otherwise a new letter is taken every cycle.
//
module longest_uniform_window_after_k_changes #(
  parameter int MAX_LEN  = 4096,
  parameter int ALPHABET = 26
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  luw_pkg::in_item_t                 in_item,
  output logic                              out_valid,
  input  logic                              out_ready,
  output luw_pkg::out_item_t                out_item,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [luw_pkg::CFG_W-1:0]         cfg_max_changes
);

  import luw_pkg::*;

  localparam int ADDR_W = $clog2(MAX_LEN);
  localparam int LEN_W  = $clog2(MAX_LEN + 1);
  localparam int CMP_W  = (LEN_W > CFG_W) ? LEN_W : CFG_W;

  // --------------------------------------------------------------------------
  // Configuration register
  // --------------------------------------------------------------------------
  logic [CFG_W-1:0] limit_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      limit_r <= cfg_max_changes;
    end
  end

  // --------------------------------------------------------------------------
  // Handshake control
  // --------------------------------------------------------------------------
  logic s1_valid_r;
  logic out_valid_r;
  logic out_free;
  logic in_xfer;
  logic s1_fire;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = !s1_valid_r || out_free;
  assign in_xfer   = in_valid && in_ready;
  assign s1_fire   = s1_valid_r && out_free;
  assign out_valid = out_valid_r;

  // --------------------------------------------------------------------------
  // Front stage: position and overflow bookkeeping, buffer write, head reads
  // --------------------------------------------------------------------------
  logic [LEN_W-1:0]  seen_r;
  logic              ovf_r;
  logic              code_ok;
  logic              room;
  logic              take;
  logic              ovf_now;
  logic [ADDR_W-1:0] pos;
  logic [ADDR_W-1:0] start_r;

  assign code_ok = 32'(in_item.letter) < ALPHABET;
  assign room    = seen_r < LEN_W'(MAX_LEN);
  assign take    = code_ok && room;
  assign ovf_now = ovf_r || (code_ok && !room);
  assign pos     = ADDR_W'(seen_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= '0;
      ovf_r  <= 1'b0;
    end else if (in_xfer) begin
      if (in_item.last_of_string) begin
        seen_r <= '0;
        ovf_r  <= 1'b0;
      end else begin
        seen_r <= seen_r + LEN_W'(take);
        ovf_r  <= ovf_now;
      end
    end
  end

  // Window buffer: one write port, two read ports with registered data.
  // Both the current head and the next one are fetched, since the item
  // ahead may still advance the head at the same edge.
  logic [LETTER_W-1:0] wl_mem [MAX_LEN];
  logic [LETTER_W-1:0] rd0_r;
  logic [LETTER_W-1:0] rd1_r;

  always_ff @(posedge clk) begin
    if (in_xfer && take) begin
      wl_mem[pos] <= in_item.letter;
    end
    if (in_xfer) begin
      rd0_r <= wl_mem[start_r];
      rd1_r <= wl_mem[start_r + ADDR_W'(1)];
    end
  end

  // Stage register
  logic [LETTER_W-1:0] s1_letter_r;
  logic                s1_last_r;
  logic                s1_take_r;
  logic                s1_ovf_r;
  logic [ADDR_W-1:0]   s1_pos_r;
  logic [ADDR_W-1:0]   s1_base_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_letter_r <= in_item.letter;
      s1_last_r   <= in_item.last_of_string;
      s1_take_r   <= take;
      s1_ovf_r    <= ovf_now;
      s1_pos_r    <= pos;
      s1_base_r   <= start_r;
    end
  end

  // --------------------------------------------------------------------------
  // Window update: histogram, top count, head advance, best length
  // --------------------------------------------------------------------------
  logic [LEN_W-1:0]    cnt_r   [ALPHABET];
  logic [LEN_W-1:0]    cnt_nxt [ALPHABET];
  logic [LEN_W-1:0]    top_r;
  logic [LEN_W-1:0]    best_r;
  logic [ALPHABET-1:0] hit_code;
  logic [ALPHABET-1:0] hit_old;
  logic [LEN_W-1:0]    cnt_sel;
  logic [LEN_W-1:0]    cnt_inc;
  logic [LEN_W-1:0]    top_new;
  logic [LEN_W-1:0]    span;
  logic [LEN_W-1:0]    diff;
  logic                shrink;
  logic [LETTER_W-1:0] old_letter;
  logic [LEN_W-1:0]    span_fin;
  logic [LEN_W-1:0]    diff_fin;
  logic [LEN_W-1:0]    best_upd;
  logic [LEN_W-1:0]    best_res;

  // The head moved since the reads were issued: take the second read.
  assign old_letter = (start_r != s1_base_r) ? rd1_r : rd0_r;

  always_comb begin
    cnt_sel = '0;
    for (int i = 0; i < ALPHABET; i++) begin
      hit_code[i] = (32'(s1_letter_r) == i);
      hit_old[i]  = (32'(old_letter) == i);
      if (hit_code[i]) begin
        cnt_sel = cnt_sel | cnt_r[i];
      end
    end
  end

  always_comb begin
    cnt_inc  = cnt_sel + LEN_W'(1);
    top_new  = (cnt_inc > top_r) ? cnt_inc : top_r;
    span     = LEN_W'(s1_pos_r) - LEN_W'(start_r) + LEN_W'(1);
    diff     = span - top_new;
    shrink   = CMP_W'(diff) > CMP_W'(limit_r);
    // Drop the head letter: window shrinks by one.
    span_fin = shrink ? span - LEN_W'(1) : span;
    diff_fin = shrink ? diff - LEN_W'(1) : diff;
    best_upd = ((CMP_W'(diff_fin) <= CMP_W'(limit_r)) && (span_fin > best_r))
               ? span_fin : best_r;
    best_res = s1_take_r ? best_upd : best_r;
  end

  always_comb begin
    for (int i = 0; i < ALPHABET; i++) begin
      cnt_nxt[i] = cnt_r[i];
      if (s1_fire) begin
        if (s1_last_r) begin
          cnt_nxt[i] = '0;
        end else if (s1_take_r) begin
          cnt_nxt[i] = cnt_r[i] + LEN_W'(hit_code[i])
                       - LEN_W'(shrink && hit_old[i]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ALPHABET; i++) begin
        cnt_r[i] <= '0;
      end
      top_r   <= '0;
      best_r  <= '0;
      start_r <= '0;
    end else begin
      for (int i = 0; i < ALPHABET; i++) begin
        cnt_r[i] <= cnt_nxt[i];
      end
      if (s1_fire) begin
        if (s1_last_r) begin
          // End of string: return to the empty window.
          top_r   <= '0;
          best_r  <= '0;
          start_r <= '0;
        end else if (s1_take_r) begin
          top_r   <= top_new;
          best_r  <= best_upd;
          start_r <= start_r + ADDR_W'(shrink);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  out_item_t out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_item_r.best_length <= BEST_W'(CMP_W'(best_res));
      out_item_r.is_final    <= s1_last_r;
      out_item_r.overflow    <= s1_ovf_r;
    end
  end

  assign out_item = out_item_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // A full, stalled output register must block the front stage.
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready && s1_valid_r) |-> !in_ready)
    else $error("input taken while the pipeline is stalled");

  // The head never passes the letter being placed.
  a_head_behind_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_take_r) |-> (start_r <= s1_pos_r))
    else $error("window head beyond current position");

  // A shrink needs at least two letters, so the head entry was written.
  a_shrink_span: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_take_r && shrink) |-> (span >= LEN_W'(2)))
    else $error("head advance on a window shorter than two");

  // Best length only grows within a string.
  a_best_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && !s1_last_r) |=> (best_r >= $past(best_r)))
    else $error("best length decreased within a string");

endmodule
